// ===== sv/msim_pkg.sv =====
// Shared codes, register indexes and constant tables for the multi-sine modulator.
package msim_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Modulation modes
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_FLICKER = 2'd1,
    MODE_PULSE   = 2'd2,
    MODE_RANDOM  = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_AMPLITUDE = 3'd4;

  localparam int unsigned NumAcc   = 5;
  localparam logic [2:0]  IncLast  = 3'd5;
  localparam logic [1:0]  PolyLast = 2'd3;

  // Innermost polynomial coefficient, Q30
  localparam logic [30:0] POLY_SEED = 31'd172272;
  // One in Q30 as a signed value
  localparam logic signed [33:0] ONE_Q30 = 34'sh040000000;
  localparam logic [14:0] SINE_MAX = 15'h7fff;

  // Frequency factor of each accumulator, Q.16
  function automatic logic [31:0] freq_factor(input logic [2:0] k);
    case (k)
      3'd0:    freq_factor = 32'd65536;
      3'd1:    freq_factor = 32'd150733;
      3'd2:    freq_factor = 32'd308019;
      3'd3:    freq_factor = 32'd45875;
      3'd4:    freq_factor = 32'd85197;
      default: freq_factor = 32'd0;
    endcase
  endfunction

  // Odd polynomial coefficients after the seed, outermost last, Q30
  function automatic logic [30:0] poly_coef(input logic [1:0] i);
    case (i)
      2'd0:    poly_coef = 31'd5026995;
      2'd1:    poly_coef = 31'd85569306;
      2'd2:    poly_coef = 31'd693598668;
      2'd3:    poly_coef = 31'd1686629713;
      default: poly_coef = 31'd0;
    endcase
  endfunction

  // Index of the last tone summed in a mode
  function automatic logic [1:0] tone_last(input mode_e m);
    case (m)
      MODE_FLICKER: tone_last = 2'd2;
      MODE_RANDOM:  tone_last = 2'd1;
      default:      tone_last = 2'd0;
    endcase
  endfunction

  // Accumulator feeding a tone
  function automatic logic [2:0] tone_acc(input mode_e m, input logic [1:0] t);
    tone_acc = 3'd0;
    case (m)
      MODE_FLICKER: tone_acc = {1'b0, t};
      MODE_RANDOM:  tone_acc = (t == 2'd0) ? 3'd3 : 3'd4;
      default:      tone_acc = 3'd0;
    endcase
  endfunction

  // Phase offset factor of a tone, Q.16
  function automatic logic [31:0] tone_ofs_factor(input mode_e m, input logic [1:0] t);
    tone_ofs_factor = 32'd65536;
    case (m)
      MODE_FLICKER: begin
        case (t)
          2'd1:    tone_ofs_factor = 32'd111411;
          2'd2:    tone_ofs_factor = 32'd150733;
          default: tone_ofs_factor = 32'd65536;
        endcase
      end
      MODE_RANDOM: begin
        tone_ofs_factor = (t == 2'd0) ? 32'd65536 : 32'd98304;
      end
      default: tone_ofs_factor = 32'd65536;
    endcase
  endfunction

  // Weight of a tone, Q16.16; pulse passes its sine through with unit weight
  function automatic logic [31:0] tone_weight(input mode_e m, input logic [1:0] t);
    tone_weight = 32'd65536;
    case (m)
      MODE_FLICKER: begin
        case (t)
          2'd0:    tone_weight = 32'd32768;
          2'd1:    tone_weight = 32'd19661;
          default: tone_weight = 32'd13107;
        endcase
      end
      MODE_RANDOM: begin
        tone_weight = (t == 2'd0) ? 32'd39322 : 32'd26214;
      end
      default: tone_weight = 32'd65536;
    endcase
  endfunction

endpackage

// ===== sv/multi_sine_intensity_modulator_unit.sv =====
// Multi-sine light intensity modulator: sequencer around one shared 32x32 multiplier.
// The input stalls while a transaction is in progress, and a finished result waits in the
// output register without blocking the next input.
// Reset (rst_ni low, asynchronous) clears the phases and loads the register defaults.
module multi_sine_intensity_modulator_unit #(
  parameter int unsigned PHASE_WIDTH          = 24,
  parameter int unsigned SINE_TABLE_ADDR_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msim_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [msim_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   delta_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   light_level_o
);
  import msim_pkg::*;

  localparam int unsigned AddrBits = SINE_TABLE_ADDR_BITS;
  localparam int unsigned QBits    = AddrBits - 2;
  localparam int unsigned XShift   = 30 - QBits;

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_PROD  = 18'h00002,
    S_INC   = 18'h00004,
    S_OFS   = 18'h00008,
    S_PHASE = 18'h00010,
    S_SQ    = 18'h00020,
    S_X2    = 18'h00040,
    S_PMUL  = 18'h00080,
    S_PSUB  = 18'h00100,
    S_XT    = 18'h00200,
    S_ROUND = 18'h00400,
    S_WGT   = 18'h00800,
    S_ACC   = 18'h01000,
    S_MSC   = 18'h02000,
    S_AMP   = 18'h04000,
    S_MIX   = 18'h08000,
    S_LVL   = 18'h10000,
    S_DONE  = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] tone_q, tone_d;

  mode_e       mode_q;
  logic [15:0] base_q, speed_q, offset_q, amp_q;
  logic [PHASE_WIDTH-1:0] acc_q [NumAcc];

  logic [15:0]        delta_q;
  logic [31:0]        pbase_q;
  logic [63:0]        prod_q;
  logic [30:0]        x_q, x2_q, t_q;
  logic [14:0]        v_q;
  logic               neg_q;
  logic signed [33:0] sum_q;
  logic [16:0]        m_mag_q;
  logic               m_neg_q;
  logic [31:0]        mult_q;
  logic [15:0]        level_q;
  logic               out_valid_q;

  logic        in_accept, done_load;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;

  logic [PHASE_WIDTH-1:0] inc_w, phase_w;
  logic [2:0]             acc_idx, acc_wr_idx;
  logic [AddrBits-1:0]    addr_w;
  logic [1:0]             quad_w;
  logic [QBits:0]         qpos_w, pos_ext_w, qsize_w;
  logic [30:0]            x_w;
  logic [31:0]            hi_w;
  logic [17:0]            v18_w;
  logic [14:0]            v_w;
  logic signed [33:0]     term_w, msum_w, mult_w;
  logic signed [17:0]     m_w;
  logic [16:0]            m_abs_w;
  logic [17:0]            lvl_hi_w;
  logic [15:0]            level_w;

  assign in_accept = in_valid_i && !in_stall_o;
  assign done_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Scaled increment or offset term from the product register
  assign inc_w      = prod_q[31 -: PHASE_WIDTH];
  assign acc_idx    = tone_acc(mode_q, tone_q);
  assign acc_wr_idx = step_q - 3'd1;

  // Fold the phase onto the first quarter wave
  assign phase_w   = acc_q[acc_idx] + inc_w;
  assign addr_w    = phase_w[PHASE_WIDTH-1 -: AddrBits];
  assign quad_w    = addr_w[AddrBits-1 -: 2];
  assign pos_ext_w = {1'b0, addr_w[QBits-1:0]};
  assign qsize_w   = {1'b1, {QBits{1'b0}}};
  assign qpos_w    = quad_w[0] ? (qsize_w - pos_ext_w) : pos_ext_w;
  assign x_w       = 31'(qpos_w) << XShift;

  // Round the Q30 sine to Q15 and clamp
  assign hi_w  = prod_q[61:30];
  assign v18_w = 18'(({1'b0, hi_w} + 33'd16384) >> 15);
  assign v_w   = (v18_w > 18'(SINE_MAX)) ? SINE_MAX : v18_w[14:0];

  // Signed weighted term and rounded modulator
  assign term_w  = neg_q ? -$signed({2'b00, prod_q[31:0]}) : $signed({2'b00, prod_q[31:0]});
  assign msum_w  = sum_q + 34'sd32768;
  assign m_w     = msum_w[33:16];
  assign m_abs_w = m_w[17] ? 17'(-m_w) : m_w[16:0];

  // Gain in Q30, clamped at zero
  assign mult_w = m_neg_q ? (ONE_Q30 - $signed({1'b0, prod_q[32:0]}))
                          : (ONE_Q30 + $signed({1'b0, prod_q[32:0]}));

  // Scale and saturate the output level
  assign lvl_hi_w = prod_q[47:30];
  assign level_w  = (lvl_hi_w[17:16] != 2'b00) ? 16'hffff : lvl_hi_w[15:0];

  // Sequence the shared multiplier
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    tone_d  = tone_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (mode_q == MODE_NONE) ? S_DONE : S_PROD;
        end
      end
      S_PROD: begin
        mul_en  = 1'b1;
        mul_a   = {16'b0, delta_q};
        mul_b   = {16'b0, speed_q};
        step_d  = 3'd0;
        state_d = S_INC;
      end
      S_INC: begin
        if (step_q != IncLast) begin
          mul_en = 1'b1;
          mul_a  = (step_q == 3'd0) ? prod_q[31:0] : pbase_q;
          mul_b  = freq_factor(step_q);
          step_d = step_q + 3'd1;
        end else begin
          tone_d  = 2'd0;
          state_d = S_OFS;
        end
      end
      S_OFS: begin
        mul_en  = 1'b1;
        mul_a   = {16'b0, offset_q};
        mul_b   = tone_ofs_factor(mode_q, tone_q);
        state_d = S_PHASE;
      end
      S_PHASE: begin
        state_d = S_SQ;
      end
      S_SQ: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, x_q};
        mul_b   = {1'b0, x_q};
        state_d = S_X2;
      end
      S_X2: begin
        step_d  = 3'd0;
        state_d = S_PMUL;
      end
      S_PMUL: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, x2_q};
        mul_b   = {1'b0, t_q};
        state_d = S_PSUB;
      end
      S_PSUB: begin
        if (step_q[1:0] == PolyLast) begin
          state_d = S_XT;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = S_PMUL;
        end
      end
      S_XT: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, x_q};
        mul_b   = {1'b0, t_q};
        state_d = S_ROUND;
      end
      S_ROUND: begin
        state_d = S_WGT;
      end
      S_WGT: begin
        mul_en  = 1'b1;
        mul_a   = {17'b0, v_q};
        mul_b   = tone_weight(mode_q, tone_q);
        state_d = S_ACC;
      end
      S_ACC: begin
        if (tone_q == tone_last(mode_q)) begin
          state_d = S_MSC;
        end else begin
          tone_d  = tone_q + 2'd1;
          state_d = S_OFS;
        end
      end
      S_MSC: begin
        state_d = S_AMP;
      end
      S_AMP: begin
        mul_en  = 1'b1;
        mul_a   = {15'b0, m_mag_q};
        mul_b   = {16'b0, amp_q};
        state_d = S_MIX;
      end
      S_MIX: begin
        state_d = S_LVL;
      end
      S_LVL: begin
        mul_en  = 1'b1;
        mul_a   = mult_q;
        mul_b   = {16'b0, base_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (done_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration registers and phase accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      tone_q      <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_NONE;
      base_q      <= 16'hffff;
      speed_q     <= '0;
      offset_q    <= '0;
      amp_q       <= '0;
      for (int i = 0; i < NumAcc; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      tone_q  <= tone_d;
      if (done_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MODE:      mode_q   <= mode_e'(cfg_data_i[1:0]);
          REG_BASE:      base_q   <= cfg_data_i;
          REG_SPEED:     speed_q  <= cfg_data_i;
          REG_OFFSET:    offset_q <= cfg_data_i;
          REG_AMPLITUDE: amp_q    <= cfg_data_i;
          default: ;
        endcase
      end
      // Advance each accumulator as its increment comes out of the multiplier
      if ((state_q == S_INC) && (step_q != 3'd0)) begin
        acc_q[acc_wr_idx] <= acc_q[acc_wr_idx] + inc_w;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      delta_q <= delta_time_i;
      sum_q   <= '0;
    end
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (state_q)
      S_INC: begin
        if (step_q == 3'd0) begin
          pbase_q <= prod_q[31:0];
        end
      end
      S_PHASE: begin
        x_q   <= x_w;
        neg_q <= quad_w[1];
        t_q   <= POLY_SEED;
      end
      S_X2:    x2_q <= prod_q[60:30];
      S_PSUB:  t_q  <= poly_coef(step_q[1:0]) - prod_q[60:30];
      S_ROUND: v_q  <= v_w;
      S_ACC:   sum_q <= sum_q + term_w;
      S_MSC: begin
        m_mag_q <= m_abs_w;
        m_neg_q <= m_w[17];
      end
      S_MIX:   mult_q <= mult_w[33] ? 32'd0 : mult_w[31:0];
      S_DONE: begin
        if (done_load) begin
          level_q <= (mode_q == MODE_NONE) ? base_q : level_w;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign light_level_o = level_q;

endmodule

// ===== sv/msim_checker.sv =====
// Port-level checks for the multi-sine modulator and their binding to the top level.
module msim_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] light_level_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(light_level_o))
    else $error("stalled result changed or dropped");

  // Go busy after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // Raise a result only at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in progress");

  // Leave the busy period with the result in the output register
  a_result_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input released without a result");

endmodule

bind multi_sine_intensity_modulator_unit msim_checker u_msim_checker (.*);

// ===== bench/multi_sine_intensity_modulator_unit_tb.sv =====
// Self-checking testbench for the multi-sine light intensity modulator.
module multi_sine_intensity_modulator_unit_tb;
  import msim_pkg::*;

  localparam int unsigned PhaseW      = 24;
  localparam int unsigned AddrBits    = 10;
  localparam int unsigned PhaseShift  = 32 - PhaseW;
  localparam bit [63:0]   QuarterSize = 64'd1 << (AddrBits - 2);
  localparam int unsigned HangLimit   = 3000;
  localparam int unsigned DrainCycles = 70;
  localparam int unsigned MaxReports  = 10;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [15:0]         delta_time_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [15:0]         light_level_o;

  // Shadow copy of the block state and registers
  bit [PhaseW-1:0] phase_acc [NumAcc];
  bit [63:0]       acc_freq_q16 [NumAcc] = '{64'd65536, 64'd150733, 64'd308019,
                                             64'd45875, 64'd85197};
  mode_e           cfg_mode   = MODE_NONE;
  bit [15:0]       cfg_base   = 16'hFFFF;
  bit [15:0]       cfg_speed  = 16'h0000;
  bit [15:0]       cfg_offset = 16'h0000;
  bit [15:0]       cfg_amp    = 16'h0000;

  logic [15:0] expected_levels [$];
  logic [15:0] want_level;
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  bit          idling_on    = 1'b0;

  multi_sine_intensity_modulator_unit #(
    .PHASE_WIDTH          (PhaseW),
    .SINE_TABLE_ADDR_BITS (AddrBits)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .delta_time_i  (delta_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .light_level_o (light_level_o)
  );

  always #6 clk_i = ~clk_i;

  // sin(pi/2 * x), x and result in Q30, truncating odd polynomial
  function automatic bit [63:0] quarter_sine(bit [63:0] x);
    bit [63:0] x2;
    bit [63:0] t;
    x2 = (x * x) >> 30;
    t  = 64'd172272;
    t  = 64'd5026995 - ((x2 * t) >> 30);
    t  = 64'd85569306 - ((x2 * t) >> 30);
    t  = 64'd693598668 - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  // Full-turn sine table entry for a phase, signed Q1.15
  function automatic longint sine_at(bit [PhaseW-1:0] ph);
    bit [AddrBits-1:0] addr;
    bit [1:0]          quad;
    bit [63:0]         pos;
    bit [63:0]         mag;
    addr = ph[PhaseW-1 -: AddrBits];
    quad = addr[AddrBits-1 -: 2];
    pos  = 64'(addr[AddrBits-3:0]);
    // mirror the second and fourth quarters
    if (quad[0]) pos = QuarterSize - pos;
    mag = (quarter_sine(pos << (30 - (AddrBits - 2))) + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  // Sine of one accumulator plus its scaled phase offset
  function automatic longint tone(int acc, bit [63:0] ofs_factor);
    bit [PhaseW-1:0] ofs;
    ofs = PhaseW'((64'(cfg_offset) * ofs_factor) >> PhaseShift);
    return sine_at(PhaseW'(phase_acc[acc] + ofs));
  endfunction

  // Round a Q.31 weighted sum to Q1.15, toward minus infinity after the half bias
  function automatic longint q15_round(longint sum);
    return (sum + 64'sd32768) >>> 16;
  endfunction

  // Advance the phases for one time step and compute the light level it yields
  function automatic bit [15:0] next_light_level(bit [15:0] delta);
    bit [63:0] prod;
    longint    m;
    longint    amp;
    longint    mult;
    bit [63:0] umult;
    bit [63:0] level;
    if (cfg_mode == MODE_NONE) return cfg_base;
    prod = 64'(delta) * 64'(cfg_speed);
    for (int k = 0; k < NumAcc; k++) begin
      phase_acc[k] = PhaseW'(phase_acc[k] + PhaseW'((prod * acc_freq_q16[k]) >> PhaseShift));
    end
    case (cfg_mode)
      MODE_FLICKER: m = q15_round(tone(0, 64'd65536) * 32768 +
                                  tone(1, 64'd111411) * 19661 +
                                  tone(2, 64'd150733) * 13107);
      MODE_PULSE:   m = tone(0, 64'd65536);
      MODE_RANDOM:  m = q15_round(tone(3, 64'd65536) * 39322 +
                                  tone(4, 64'd98304) * 26214);
      default:      m = 0;
    endcase
    amp  = cfg_amp;
    mult = (64'sd1 <<< 30) + m * amp;
    // a negative multiplier blacks the light out
    if (mult < 0) mult = 0;
    umult = mult;
    level = (64'(cfg_base) * umult) >> 30;
    return (level > 64'd65535) ? 16'hFFFF : level[15:0];
  endfunction

  function automatic void apply_write(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    case (idx)
      REG_MODE:      cfg_mode   = mode_e'(data[1:0]);
      REG_BASE:      cfg_base   = data;
      REG_SPEED:     cfg_speed  = data;
      REG_OFFSET:    cfg_offset = data;
      REG_AMPLITUDE: cfg_amp    = data;
      default:       ;
    endcase
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("%s", msg);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned sender_gap();
    return $urandom_range(0, 1) ? 0 : pick_gap();
  endfunction

  function automatic bit [15:0] edge16();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [15:0] random_delta();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Result stall: random runs while idling is on
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!idling_on || $urandom_range(0, 2) != 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= pick_gap() - 1;
    end
  end

  // Compare each result transaction with the oldest expected level
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        note_failure($sformatf("unexpected light_level %0d with nothing pending",
                               light_level_o));
      end else begin
        want_level = expected_levels.pop_front();
        if (light_level_o !== want_level)
          note_failure($sformatf("light_level mismatch: expected %0d, got %0d",
                                 want_level, light_level_o));
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HangLimit) begin
      $display("multi_sine_intensity_modulator_unit verification failed");
      $finish;
    end
  end

  // Hold the input off until every pending result has been taken
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    apply_write(idx, data);
  endtask

  task automatic configure(input logic [15:0] mode_word, input logic [15:0] base,
                           input logic [15:0] speed, input logic [15:0] offset,
                           input logic [15:0] amp);
    wait_idle();
    write_reg(REG_MODE, mode_word);
    write_reg(REG_BASE, base);
    write_reg(REG_SPEED, speed);
    write_reg(REG_OFFSET, offset);
    write_reg(REG_AMPLITUDE, amp);
    cfg_we_i <= 1'b0;
  endtask

  // Send one time step; keep valid high so back-to-back transactions need no drop
  task automatic send_delta(input logic [15:0] delta);
    int unsigned gap;
    gap = idling_on ? sender_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    delta_time_i <= delta;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels.push_back(next_light_level(delta));
  endtask

  // Defaults after reset: mode none passes full scale through
  task automatic check_reset_state();
    idling_on = 1'b0;
    send_delta(16'h0000);
    send_delta(16'hFFFF);
  endtask

  // Mode data is masked to two bits; writes past the register file are dropped
  task automatic check_register_writes();
    configure(16'hFFFE, 16'h8000, 16'h4000, 16'h0000, 16'h8000);
    send_delta(16'h0001);
    wait_idle();
    for (int i = REG_AMPLITUDE + 1; i < (1 << CfgIdxW); i++) write_reg(CfgIdxW'(i), 16'hFFFF);
    cfg_we_i <= 1'b0;
    send_delta(16'h0001);
  endtask

  // Mode none must leave the phases untouched
  task automatic check_mode_none_hold();
    configure(16'(MODE_NONE), 16'h1234, 16'hFFFF, 16'h0000, 16'h7FFF);
    send_delta(16'hFFFF);
    send_delta(16'h5555);
    configure(16'(MODE_PULSE), 16'h8000, 16'h4000, 16'h0000, 16'h8000);
    send_delta(16'h0000);
  endtask

  // Quarter-turn steps hit every table quadrant edge and wrap the phase
  task automatic check_quadrant_walk();
    configure(16'(MODE_PULSE), 16'h8000, 16'h4000, 16'h0000, 16'h8000);
    repeat (5) send_delta(16'h0001);
  endtask

  // Full depth: positive peak saturates, negative peak clamps to zero
  task automatic check_multiplier_limits();
    configure(16'(MODE_PULSE), 16'hFFFF, 16'h4000, 16'h0000, 16'hFFFF);
    repeat (4) send_delta(16'h0001);
    configure(16'(MODE_PULSE), 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_delta(16'hFFFF);
  endtask

  task automatic check_all_modes();
    configure(16'(MODE_FLICKER), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_delta(16'hFFFF);
    send_delta(16'h0000);
    configure(16'(MODE_RANDOM), 16'hAAAA, 16'h5555, 16'h8001, 16'h4000);
    send_delta(16'h1234);
    send_delta(16'hFFFF);
  endtask

  // Random settings per phase, random time steps, some phases without idling
  task automatic run_random_traffic();
    mode_e mode;
    for (int ph = 0; ph < 18; ph++) begin
      idling_on = (ph % 4 != 1);
      mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : mode_e'($urandom_range(1, 3));
      configure({14'($urandom), 2'(mode)}, edge16(), edge16(), edge16(), edge16());
      for (int n = 0; n < 74; n++) begin
        if (n == 37 && $urandom_range(0, 2) == 0) wait_idle();
        send_delta(random_delta());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reset_state();
    check_register_writes();
    check_mode_none_hold();
    check_quadrant_walk();
    check_multiplier_limits();
    check_all_modes();
    run_random_traffic();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_levels.size() == 0) begin
      $display("multi_sine_intensity_modulator_unit verification clean");
    end else begin
      $display("multi_sine_intensity_modulator_unit verification failed");
    end
    $finish;
  end

endmodule
